### rtl/mcr_pkg.sv
// Shared constants, types and octant mapping for the midpoint circle rasterizer.
package mcr_pkg;

    localparam int OUT_BITS     = 13;
    localparam int PIX_PER_STEP = 8;
    localparam int IDX_BITS     = $clog2(PIX_PER_STEP);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(PIX_PER_STEP - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic swap;
    } octant_t;

    typedef struct packed {
        logic last_of_step;
        logic circle_done;
    } pix_flags_t;

    function automatic octant_t octant_of(input logic [IDX_BITS-1:0] idx);
        octant_t o;
        o.swap  = idx[0];
        o.neg_x = idx[1] ^ idx[2];
        o.neg_y = idx[2];
        return o;
    endfunction

endpackage

### rtl/mcr_front.sv
// Front end: takes commands, holds the circle walk state, issues a job per active step.
module mcr_front #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10,
    parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   cmd,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic                   q_full,
    output logic                   full,
    output logic                   job_push,
    output logic [JOB_BITS-1:0]    job_data
);

    localparam int PB = RADIUS_BITS + 3;

    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [RADIUS_BITS-1:0] x_reg, y_reg;
    logic signed [PB-1:0]   p_reg;
    logic                   active_reg;

    logic [COORD_BITS-1:0]  cx_next, cy_next;
    logic [RADIUS_BITS-1:0] x_next, y_next;
    logic signed [PB-1:0]   p_next;
    logic                   active_next;

    logic                   accept;
    logic [RADIUS_BITS-1:0] x_inc, y_dec, y_new;
    logic signed [PB-1:0]   term, p_step;
    logic                   p_neg, done;

    assign full   = q_full;
    assign accept = push && !full;

    always_comb
    begin
        x_inc  = x_reg + RADIUS_BITS'(1);
        y_dec  = (y_reg != '0) ? y_reg - RADIUS_BITS'(1) : y_reg;
        p_neg  = p_reg[PB-1];
        y_new  = p_neg ? y_reg : y_dec;
        term   = p_neg ? $signed({3'b000, x_inc})
                       : $signed({3'b000, x_inc}) - $signed({3'b000, y_new});
        p_step = p_reg + (term <<< 1) + PB'(1);
        done   = (y_new < x_inc);
    end

    assign job_push = accept && (cmd == mcr_pkg::CMD_STEP) && active_reg;
    assign job_data = {cx_reg, cy_reg, x_reg, y_reg, done};

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (cmd == mcr_pkg::CMD_START)
            begin
                cx_next     = center_x;
                cy_next     = center_y;
                x_next      = '0;
                y_next      = radius;
                p_next      = PB'(1) - $signed({3'b000, radius});
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                x_next      = x_inc;
                y_next      = y_new;
                p_next      = p_step;
                active_next = !done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            p_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            p_reg      <= p_next;
            active_reg <= active_next;
        end
    end

endmodule

### rtl/mcr_queue.sv
// Short job queue between the front end and the pixel emitter.
module mcr_queue #(
    parameter int WIDTH = 43
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] mem [mcr_pkg::QUEUE_DEPTH];

    logic [mcr_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcr_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcr_pkg::QCNT_BITS-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full    = (count_reg == mcr_pkg::QCNT_BITS'(mcr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mcr_pkg::QPTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + mcr_pkg::QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mcr_pkg::QPTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + mcr_pkg::QPTR_BITS'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + mcr_pkg::QCNT_BITS'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - mcr_pkg::QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/mcr_back.sv
// Back end: eight symmetric pixels per job into the output register, one per cycle unless stalled.
module mcr_back #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10,
    parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  logic [JOB_BITS-1:0]                 job_data,
    output logic                                job_pop,
    output logic signed [mcr_pkg::OUT_BITS-1:0] pixel_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0] pixel_y,
    output mcr_pkg::pix_flags_t                 flags,
    output logic                                empty,
    input  logic                                pop
);

    localparam int MAXB  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int SUMB  = MAXB + 2;
    localparam int WIDE  = (SUMB > mcr_pkg::OUT_BITS) ? SUMB : mcr_pkg::OUT_BITS;

    logic [COORD_BITS-1:0]  job_cx, job_cy;
    logic [RADIUS_BITS-1:0] job_x, job_y;
    logic                   job_done;

    logic [mcr_pkg::IDX_BITS-1:0] idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    logic [mcr_pkg::OUT_BITS-1:0] px_reg, py_reg;
    mcr_pkg::pix_flags_t          flags_reg;

    mcr_pkg::octant_t       oct;
    logic [RADIUS_BITS-1:0] off_a, off_b;
    logic signed [WIDE-1:0] cx_w, cy_w, a_w, b_w, px_w, py_w;
    logic                   advance, last;

    assign {job_cx, job_cy, job_x, job_y, job_done} = job_data;

    assign advance = job_valid && (!out_valid_reg || pop);
    assign last    = (idx_reg == mcr_pkg::IDX_LAST);
    assign job_pop = advance && last;

    always_comb
    begin
        oct   = mcr_pkg::octant_of(idx_reg);
        off_a = oct.swap ? job_y : job_x;
        off_b = oct.swap ? job_x : job_y;
        cx_w  = $signed(WIDE'(job_cx));
        cy_w  = $signed(WIDE'(job_cy));
        a_w   = $signed(WIDE'(off_a));
        b_w   = $signed(WIDE'(off_b));
        px_w  = oct.neg_x ? cx_w - a_w : cx_w + a_w;
        py_w  = oct.neg_y ? cy_w - b_w : cy_w + b_w;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            idx_next       = idx_reg + mcr_pkg::IDX_BITS'(1);
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg                 <= px_w[mcr_pkg::OUT_BITS-1:0];
            py_reg                 <= py_w[mcr_pkg::OUT_BITS-1:0];
            flags_reg.last_of_step <= last;
            flags_reg.circle_done  <= last && job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pixel_x = $signed(px_reg);
    assign pixel_y = $signed(py_reg);
    assign flags   = flags_reg;
    assign empty   = !out_valid_reg;

endmodule

### rtl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: front end, job queue and pixel emitter.
//
// channel  direction  handshake    payload
// command  in         push / full  cmd, center_x, center_y, radius
// pixel    out        pop / empty  pixel_x, pixel_y, last_of_step, circle_done
//
// A step command yields eight pixels, one per cycle from the emitter while pop is held;
// the emitter's single pixel port limits how fast steps are taken.
// A start or an idle step yields no pixels.
// Reset clears the walk, the queue and the output valid flag; no circle is active after it.
// full rises while the two-entry job queue holds two jobs; a withheld pop stalls the
// emitter first and reaches the command side only once the queue fills.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                cmd,
    input  logic [COORD_BITS-1:0]               center_x,
    input  logic [COORD_BITS-1:0]               center_y,
    input  logic [RADIUS_BITS-1:0]              radius,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mcr_pkg::OUT_BITS-1:0] pixel_x,
    output logic signed [mcr_pkg::OUT_BITS-1:0] pixel_y,
    output logic                                last_of_step,
    output logic                                circle_done
);

    localparam int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

    logic                q_full, q_empty, job_push, job_pop;
    logic [JOB_BITS-1:0] job_in, job_out;
    mcr_pkg::pix_flags_t flags;

    mcr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_BITS    (JOB_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .cmd      (cmd),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job_data (job_in)
    );

    mcr_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (q_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (q_empty)
    );

    mcr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_BITS    (JOB_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .flags     (flags),
        .empty     (empty),
        .pop       (pop)
    );

    assign last_of_step = flags.last_of_step;
    assign circle_done  = flags.circle_done;

endmodule

### tb/sv/midpoint_circle_rasterizer_test.sv
// Self-checking bench for the midpoint circle rasterizer: octant walks, restarts and idle steps.
module midpoint_circle_rasterizer_test;

    localparam int COORD_BITS  = 11;
    localparam int RADIUS_BITS = 10;
    localparam int ITEM_TARGET = 500;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 20;

    typedef struct {
        logic                   op;
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] r;
    } circle_cmd_t;

    typedef struct {
        logic signed [mcr_pkg::OUT_BITS-1:0] px;
        logic signed [mcr_pkg::OUT_BITS-1:0] py;
        logic                                last;
        logic                                done;
    } pixel_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                push         = 1'b0;
    logic                                cmd          = mcr_pkg::CMD_START;
    logic [COORD_BITS-1:0]               center_x     = '0;
    logic [COORD_BITS-1:0]               center_y     = '0;
    logic [RADIUS_BITS-1:0]              radius       = '0;
    logic                                pop          = 1'b0;
    logic                                full;
    logic                                empty;
    logic signed [mcr_pkg::OUT_BITS-1:0] pixel_x;
    logic signed [mcr_pkg::OUT_BITS-1:0] pixel_y;
    logic                                last_of_step;
    logic                                circle_done;

    circle_cmd_t cmd_backlog[$];
    pixel_t      pending_pixels[$];
    pixel_t      pix_want;

    logic [COORD_BITS-1:0]               held_cx;
    logic [COORD_BITS-1:0]               held_cy;
    logic [RADIUS_BITS-1:0]              off_x;
    logic [RADIUS_BITS-1:0]              off_y;
    logic signed [mcr_pkg::OUT_BITS-1:0] decision;
    logic                                walk_on;

    int  items_done     = 0;
    int  starts_seen    = 0;
    int  pixels_checked = 0;
    int  circles_closed = 0;
    int  errors         = 0;
    int  stall_cycles   = 0;
    bit  calm           = 1'b0;

    midpoint_circle_rasterizer #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .empty        (empty),
        .pop          (pop),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_pct();
        return calm ? 0 : 9;
    endfunction

    task automatic trace_octant_step(input logic op, input logic [COORD_BITS-1:0] ncx,
                                     input logic [COORD_BITS-1:0] ncy,
                                     input logic [RADIUS_BITS-1:0] nr);
        int     cx;
        int     cy;
        int     x;
        int     y;
        int     px[8];
        int     py[8];
        bit     fin;
        pixel_t pix;
        if (op == mcr_pkg::CMD_START)
        begin
            held_cx  = ncx;
            held_cy  = ncy;
            off_x    = '0;
            off_y    = nr;
            decision = mcr_pkg::OUT_BITS'(1 - int'(nr));
            walk_on  = 1'b1;
            starts_seen++;
            items_done++;
            return;
        end
        if (!walk_on)
            return;
        cx = int'(held_cx);
        cy = int'(held_cy);
        x  = int'(off_x);
        y  = int'(off_y);
        px = '{cx + x, cx + y, cx - x, cx - y, cx - x, cx - y, cx + x, cx + y};
        py = '{cy + y, cy + x, cy + y, cy + x, cy - y, cy - x, cy - y, cy - x};
        x  = x + 1;
        if (decision < 0)
            decision = mcr_pkg::OUT_BITS'(int'(decision) + 2 * x + 1);
        else
        begin
            if (y > 0)
                y = y - 1;
            decision = mcr_pkg::OUT_BITS'(int'(decision) + 2 * (x - y) + 1);
        end
        off_x = RADIUS_BITS'(x);
        off_y = RADIUS_BITS'(y);
        fin   = (y < x);
        if (fin)
            walk_on = 1'b0;
        for (int k = 0; k < mcr_pkg::PIX_PER_STEP; k++)
        begin
            pix.px   = mcr_pkg::OUT_BITS'(px[k]);
            pix.py   = mcr_pkg::OUT_BITS'(py[k]);
            pix.last = (k == mcr_pkg::PIX_PER_STEP - 1);
            pix.done = (k == mcr_pkg::PIX_PER_STEP - 1) && fin;
            pending_pixels.push_back(pix);
        end
        items_done++;
    endtask

    task automatic queue_cmd(input logic op, input int ncx, input int ncy, input int nr);
        circle_cmd_t c;
        c.op = op;
        c.cx = COORD_BITS'(ncx);
        c.cy = COORD_BITS'(ncy);
        c.r  = RADIUS_BITS'(nr);
        cmd_backlog.push_back(c);
    endtask

    // Driver: hold the item until the transfer, then advance from the backlog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            cmd      <= mcr_pkg::CMD_START;
            center_x <= '0;
            center_y <= '0;
            radius   <= '0;
        end
        else
        begin
            if (push && !full)
                trace_octant_step(cmd, center_x, center_y, radius);
            if (!push || !full)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct())
                begin
                    push     <= 1'b1;
                    cmd      <= cmd_backlog[0].op;
                    center_x <= cmd_backlog[0].cx;
                    center_y <= cmd_backlog[0].cy;
                    radius   <= cmd_backlog[0].r;
                    cmd_backlog.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: check every pixel transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                pixels_checked++;
                if (circle_done === 1'b1)
                    circles_closed++;
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected pixel (%0d, %0d)", pixel_x, pixel_y);
                    errors++;
                end
                else
                begin
                    pix_want = pending_pixels.pop_front();
                    if (pixel_x !== pix_want.px)
                    begin
                        $error("pixel_x expected %0d actual %0d", pix_want.px, pixel_x);
                        errors++;
                    end
                    if (pixel_y !== pix_want.py)
                    begin
                        $error("pixel_y expected %0d actual %0d", pix_want.py, pixel_y);
                        errors++;
                    end
                    if (last_of_step !== pix_want.last)
                    begin
                        $error("last_of_step expected %0b actual %0b", pix_want.last,
                               last_of_step);
                        errors++;
                    end
                    if (circle_done !== pix_want.done)
                    begin
                        $error("circle_done expected %0b actual %0b", pix_want.done,
                               circle_done);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= idle_pct());
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int  roll;
        int  r;
        int  steps;
        bit  drained;
        drained = 1'b0;
        held_cx  = '0;
        held_cy  = '0;
        off_x    = '0;
        off_y    = '0;
        decision = '0;
        walk_on  = 1'b0;

        // step with nothing active, then degenerate and extreme circles
        queue_cmd(mcr_pkg::CMD_STEP, 2047, 2047, 1023);
        queue_cmd(mcr_pkg::CMD_START, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_START, 2047, 2047, 1023);
        repeat (3) queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_START, 0, 0, 1023);
        repeat (2) queue_cmd(mcr_pkg::CMD_STEP, 2047, 2047, 1023);
        queue_cmd(mcr_pkg::CMD_START, 1000, 5, 1);
        repeat (2) queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_START, 2047, 0, 2);
        repeat (3) queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_START, 1365, 682, 682);
        repeat (2) queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);
        queue_cmd(mcr_pkg::CMD_START, 682, 1365, 341);
        queue_cmd(mcr_pkg::CMD_STEP, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_done < ITEM_TARGET)
        begin
            while (cmd_backlog.size() > 8)
                @(posedge clk);
            calm = (items_done >= 100 && items_done < 200);
            if (!drained && items_done >= ITEM_TARGET / 2)
            begin
                while (cmd_backlog.size() != 0 || push || pending_pixels.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                repeat ($urandom_range(1, 4))
                    queue_cmd($urandom_range(1), $urandom, $urandom, $urandom);
            end
            else
            begin
                if (roll < 70)
                    r = $urandom_range(0, 24);
                else if (roll < 90)
                    r = $urandom_range(25, 200);
                else
                    r = $urandom_range(0, 1023);
                queue_cmd(mcr_pkg::CMD_START, $urandom, $urandom, r);
                if (r <= 24 && roll >= 15)
                    steps = r * 707 / 1000 + 1 + $urandom_range(0, 2);
                else if (r <= 24)
                    steps = $urandom_range(1, r * 707 / 1000 + 1);
                else
                    steps = $urandom_range(1, 12);
                repeat (steps)
                    queue_cmd(mcr_pkg::CMD_STEP, $urandom, $urandom, $urandom);
            end
        end

        while (cmd_backlog.size() != 0 || push || pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d productive commands, %0d circle starts", items_done, starts_seen);
        $display("checked %0d pixels, %0d circles walked to the end", pixels_checked,
                 circles_closed);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
